// File: rtl/tfld_pkg.sv
`timescale 1ns / 1ps
package tfld_pkg;

  localparam int COEF_REGS   = 5;
  localparam int COEF_BITS   = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int Q_BITS      = 16;
  localparam int VAL_W       = 9;
  localparam int PWM_W       = 5;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  localparam coef_t COEF_DEFAULT = 17'sd13107;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF4 = 3'd5;

  localparam logic [VAL_W-1:0] LEVEL_OFFSET = 9'h1e0;  // -32
  localparam logic [PWM_W-1:0] PWM_LAST     = 5'd16;   // wrap when above

  typedef enum logic [0:0] {
    ITEM_SAMPLE = 1'b0,
    ITEM_TICK   = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic       valid;
    item_kind_t kind;
  } head_t;

  function automatic logic [7:0] led_of(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0: r = 8'h08;
      3'd1: r = 8'h04;
      3'd2: r = 8'h02;
      3'd3: r = 8'h01;
      3'd4: r = 8'h80;
      3'd5: r = 8'h40;
      3'd6: r = 8'h20;
      3'd7: r = 8'h10;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/tfld_front.sv
`timescale 1ns / 1ps
module tfld_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          pop,
  output tfld_pkg::head_t               head,
  output logic signed [SAMPLE_BITS-1:0] head_sample
);
  import tfld_pkg::*;

  item_kind_t                    kind_mem   [2];
  logic signed [SAMPLE_BITS-1:0] sample_mem [2];
  logic                          rd_ptr;
  logic                          wr_ptr;
  logic [1:0]                    count;
  logic                          push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // classify on entry
  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr]   <= item_kind_t'(command);
      sample_mem[wr_ptr] <= sample;
    end
  end

  assign head.valid  = (count != 2'd0);
  assign head.kind   = kind_mem[rd_ptr];
  assign head_sample = sample_mem[rd_ptr];

endmodule

// File: rtl/tfld_back.sv
`timescale 1ns / 1ps
module tfld_back #(
  parameter int TAPS        = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tfld_pkg::head_t               head,
  input  logic signed [SAMPLE_BITS-1:0] head_sample,
  output logic                          pop,
  input  logic [1:0]                    mode,
  input  tfld_pkg::coef_t               coef [tfld_pkg::COEF_REGS],
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    leds
);
  import tfld_pkg::*;

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + $clog2(TAPS);

  logic                          en;
  logic                          filt_now;
  logic signed [SAMPLE_BITS-1:0] taps_q  [TAPS];
  logic signed [SAMPLE_BITS-1:0] line_in [TAPS];
  coef_t                         coef_sel [TAPS];
  logic signed [PROD_W-1:0]      prod_d  [TAPS];
  logic signed [PROD_W-1:0]      prod_q  [TAPS];

  logic                          s1_valid;
  item_kind_t                    s1_kind;
  logic                          s1_filt;
  logic signed [SAMPLE_BITS-1:0] s1_sample;

  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       adj;
  logic signed [SUM_W-1:0]       quot;
  logic signed [SUM_W-1:0]       byp;
  logic [VAL_W-1:0]              filt_low;
  logic [VAL_W-1:0]              val;

  logic [7:0]                    base_pattern;
  logic [PWM_W-1:0]              drive_level;
  logic [PWM_W-1:0]              pwm_count;

  assign en       = !out_valid || !out_stall;
  assign pop      = en && head.valid;
  assign filt_now = (head.kind == ITEM_SAMPLE) && (mode[0] ^ mode[1]);

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    if (i < COEF_REGS) begin : g_reg
      assign coef_sel[i] = coef[i];
    end else begin : g_fix
      assign coef_sel[i] = COEF_DEFAULT;
    end
    if (i == 0) begin : g_new
      assign line_in[i] = head_sample;
    end else begin : g_old
      assign line_in[i] = taps_q[i-1];
    end
    assign prod_d[i] = PROD_W'(coef_sel[i]) * PROD_W'(line_in[i]);
  end

  // delay line, newest in slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        taps_q[i] <= '0;
      end
    end else if (pop && filt_now) begin
      for (int i = 0; i < TAPS; i++) begin
        taps_q[i] <= line_in[i];
      end
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind   <= head.kind;
      s1_filt   <= filt_now;
      s1_sample <= head_sample;
      prod_q    <= prod_d;
    end
  end

  // sum, truncate toward zero, pick filtered or bypass sample, offset
  always_comb begin
    sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum = sum + SUM_W'(prod_q[i]);
    end
    adj      = sum[SUM_W-1] ? sum + SUM_W'((1 << Q_BITS) - 1) : sum;
    quot     = adj >>> Q_BITS;
    byp      = SUM_W'(s1_sample);
    filt_low = s1_filt ? quot[VAL_W-1:0] : byp[VAL_W-1:0];
    val      = filt_low + LEVEL_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      base_pattern <= '0;
      drive_level  <= '0;
      pwm_count    <= '0;
    end else if (en) begin
      out_valid <= s1_valid && (s1_kind == ITEM_TICK);
      if (s1_valid) begin
        if (s1_kind == ITEM_TICK) begin
          pwm_count <= (pwm_count > PWM_LAST) ? '0 : pwm_count + 1'b1;
        end else begin
          base_pattern <= led_of(val[8:6]);
          drive_level  <= val[5:1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid && (s1_kind == ITEM_TICK)) begin
      leds <= (pwm_count < drive_level) ? {1'b0, base_pattern[7:1]} : base_pattern;
    end
  end

endmodule

// File: rtl/tilt_fir_led_pwm_display_top.sv
`timescale 1ns / 1ps
// Tilt display: each accepted word is a sample (command 0) or a timer tick (command 1).
// A sample, optionally run through a TAPS-tap Q16 FIR, sets the one-hot LED pointer and
// its dim level; each tick returns one leds word, with the pointer shifted down one bit
// while the 0..17 PWM counter is below the level. One word is accepted per cycle while
// in_stall is low; a tick's result passes through the two-word input queue and the
// registered product stage, then sits in the output register.
module tilt_fir_led_pwm_display_top #(
  parameter int TAPS        = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          leds,
  input  logic                                cfg_we,
  input  logic [tfld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfld_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tfld_pkg::*;

  logic [1:0]                    filter_mode;
  coef_t                         coef [COEF_REGS];
  head_t                         head;
  logic signed [SAMPLE_BITS-1:0] head_sample;
  logic                          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= 2'd0;
      for (int i = 0; i < COEF_REGS; i++) begin
        coef[i] <= COEF_DEFAULT;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        filter_mode <= cfg_data[1:0];
      end else if (cfg_index inside {[CFG_COEF0:CFG_COEF4]}) begin
        coef[3'(cfg_index - CFG_COEF0)] <= coef_t'(cfg_data);
      end
    end
  end

  tfld_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .sample     (sample),
    .pop        (pop),
    .head       (head),
    .head_sample(head_sample)
  );

  tfld_back #(
    .TAPS       (TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_sample(head_sample),
    .pop        (pop),
    .mode       (filter_mode),
    .coef       (coef),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .leds       (leds)
  );

  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (head.valid && !pop) |=> head.valid)
    else $error("queued word lost");

  a_pointer_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(leds) <= 1))
    else $error("led pattern not one-hot or zero");

  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !in_stall))
    else $error("handshake not idle after reset");

endmodule
